@@ rtl/decaying_level_table_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the decaying level table
// Shared forms for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef DECAYING_LEVEL_TABLE_DEFINES_SVH
`define DECAYING_LEVEL_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DLT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decaying level table: check failed");

// Next-cycle implication, disabled during reset.
`define DLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decaying level table: check failed");

`endif

@@ rtl/dlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Decaying level table package
// Widths, opcodes, fixed-point constants and the default decay rate table.
// ----------------------------------------------------------------------------
package dlt_pkg;

    localparam int ENTRIES     = 256;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int LEVEL_W     = 24;
    localparam int RATE_W      = 20;
    localparam int VAL_W       = 25;
    localparam int DT_W        = 24;
    localparam int SNAP_W      = 16;
    localparam int X_W         = RATE_W + DT_W;
    localparam int FAC_W       = 17;
    localparam int NAMED_COUNT = 61;

    localparam logic [X_W-1:0]     KDT_SMALL = 44'd429496730;
    localparam logic [32:0]        ONE32     = 33'h1_0000_0000;
    // exp(-1) in Q0.32
    localparam logic [31:0]        EXP_ONE   = 32'd1580030169;
    localparam logic [RATE_W-1:0]  RATE_MAX  = 20'hFFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFFFFFF;

    localparam logic [LEVEL_W-1:0] FLOOR_RST   = 24'd0;
    localparam logic [LEVEL_W-1:0] CEILING_RST = 24'd65536;
    localparam logic [SNAP_W-1:0]  SNAP_RST    = 16'd66;

    typedef enum logic [2:0] {
        OP_SET      = 3'd0,
        OP_ADD      = 3'd1,
        OP_CONSUME  = 3'd2,
        OP_SET_RATE = 3'd3,
        OP_DECAY    = 3'd4,
        OP_READ     = 3'd5
    } dlt_op_t;

    typedef enum logic [1:0] {
        REG_FLOOR   = 2'd0,
        REG_CEILING = 2'd1,
        REG_SNAP    = 2'd2
    } dlt_reg_t;

    // Status of the decay factor unit seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } dlt_fac_stat_t;

    localparam logic [RATE_W-1:0] DEFAULT_RATE [0:NAMED_COUNT-1] = '{
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd5243, 20'd2621, 20'd1311, 20'd0, 20'd0,
        20'd1966, 20'd1966, 20'd1311, 20'd1311, 20'd3277, 20'd655, 20'd1311, 20'd6554,
        20'd1311, 20'd5243,
        20'd6554, 20'd1966, 20'd0, 20'd0, 20'd0, 20'd0, 20'd13107, 20'd3277, 20'd3277,
        20'd6554,
        20'd2621, 20'd9830, 20'd5243, 20'd7864, 20'd7864, 20'd7864, 20'd328, 20'd2621,
        20'd5243, 20'd9830,
        20'd197, 20'd6554, 20'd0, 20'd0, 20'd0, 20'd0, 20'd52429, 20'd52429, 20'd655,
        20'd3277,
        20'd13107
    };

    function automatic logic [RATE_W-1:0] default_rate(input logic [7:0] idx);
        logic [RATE_W-1:0] r;
        r = '0;
        if (idx < 8'(NAMED_COUNT)) begin
            r = DEFAULT_RATE[idx[5:0]];
        end
        return r;
    endfunction

endpackage

@@ rtl/dlt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module dlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dlt_factor.sv @@
// ----------------------------------------------------------------------------
// Decay factor unit
// Turns x = rate * time step (Q12.32) into exp(-x) rounded to Q1.16.
// ----------------------------------------------------------------------------
`include "decaying_level_table_defines.svh"

module dlt_factor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dlt_pkg::X_W-1:0]     x,
    output dlt_pkg::dlt_fac_stat_t      stat,
    output logic [dlt_pkg::FAC_W-1:0]   factor
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_MUL, S_SQ_SUM, S_T_MUL, S_T_LOAD, S_T_DIV,
        S_P_MUL, S_P_TAKE, S_F_MUL, S_F_TAKE, S_ROUND
    } state_t;

    state_t                      state_reg;
    logic [dlt_pkg::X_W-1:0]     x_reg;
    logic [31:0]                 frac_reg;
    logic [3:0]                  n_reg;
    logic [32:0]                 term_reg;
    logic [33:0]                 sum_reg;
    logic [3:0]                  k_reg;
    logic [32:0]                 en_reg;
    logic [3:0]                  i_reg;
    logic [65:0]                 mul_reg;
    logic [31:0]                 div_reg;
    logic [3:0]                  rem_reg;
    logic [1:0]                  cnt_reg;
    logic [33:0]                 f32_reg;
    logic [dlt_pkg::FAC_W-1:0]   factor_reg;
    logic                        done_reg;

    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [31:0] div_next;
    logic [3:0]  rem_next;
    logic [18:0] rnd;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = x_reg[32:0];
                mul_b = x_reg[32:0];
            end
            S_T_MUL:
            begin
                mul_a = term_reg;
                mul_b = {1'b0, frac_reg};
            end
            S_P_MUL:
            begin
                mul_a = en_reg;
                mul_b = {1'b0, dlt_pkg::EXP_ONE};
            end
            S_F_MUL:
            begin
                mul_a = sum_reg[32:0];
                mul_b = en_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Restoring division by the term index, eight quotient bits a cycle.
    always_comb
    begin
        logic [4:0]  t;
        logic [3:0]  r;
        logic [31:0] d;
        r = rem_reg;
        d = div_reg;
        for (int j = 0; j < 8; j++)
        begin
            t = {r, d[31]};
            d = {d[30:0], 1'b0};
            if (t >= {1'b0, k_reg})
            begin
                t = t - {1'b0, k_reg};
                d[0] = 1'b1;
            end
            r = t[3:0];
        end
        div_next = d;
        rem_next = r;
    end

    assign rnd = 19'((35'(f32_reg) + 35'd32768) >> 16);

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            x_reg      <= '0;
            frac_reg   <= '0;
            n_reg      <= '0;
            term_reg   <= '0;
            sum_reg    <= '0;
            k_reg      <= 4'd1;
            en_reg     <= '0;
            i_reg      <= '0;
            div_reg    <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            f32_reg    <= '0;
            factor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg <= x;
                        if (x < dlt_pkg::KDT_SMALL)
                        begin
                            state_reg <= S_SQ_MUL;
                        end
                        else if (x[43:32] >= 12'd12)
                        begin
                            // The factor underflows to zero.
                            f32_reg   <= '0;
                            state_reg <= S_ROUND;
                        end
                        else
                        begin
                            frac_reg  <= x[31:0];
                            n_reg     <= x[35:32];
                            term_reg  <= dlt_pkg::ONE32;
                            sum_reg   <= 34'(dlt_pkg::ONE32);
                            k_reg     <= 4'd1;
                            state_reg <= S_T_MUL;
                        end
                    end
                end
                S_SQ_MUL:
                begin
                    state_reg <= S_SQ_SUM;
                end
                S_SQ_SUM:
                begin
                    f32_reg   <= 34'(dlt_pkg::ONE32) - 34'(x_reg) + 34'(mul_reg[65:33]);
                    state_reg <= S_ROUND;
                end
                S_T_MUL:
                begin
                    state_reg <= S_T_LOAD;
                end
                S_T_LOAD:
                begin
                    div_reg   <= mul_reg[63:32];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_T_DIV;
                end
                S_T_DIV:
                begin
                    div_reg <= div_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        term_reg <= {1'b0, div_next};
                        if (k_reg[0])
                        begin
                            sum_reg <= sum_reg - 34'(div_next);
                        end
                        else
                        begin
                            sum_reg <= sum_reg + 34'(div_next);
                        end
                        if (k_reg == 4'd12)
                        begin
                            en_reg    <= dlt_pkg::ONE32;
                            i_reg     <= '0;
                            state_reg <= S_P_MUL;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 4'd1;
                            state_reg <= S_T_MUL;
                        end
                    end
                end
                S_P_MUL:
                begin
                    if (i_reg == n_reg)
                    begin
                        state_reg <= S_F_MUL;
                    end
                    else
                    begin
                        state_reg <= S_P_TAKE;
                    end
                end
                S_P_TAKE:
                begin
                    en_reg    <= mul_reg[64:32];
                    i_reg     <= i_reg + 4'd1;
                    state_reg <= S_P_MUL;
                end
                S_F_MUL:
                begin
                    state_reg <= S_F_TAKE;
                end
                S_F_TAKE:
                begin
                    f32_reg   <= 34'(mul_reg[65:32]);
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (rnd > 19'd65536)
                    begin
                        factor_reg <= 17'd65536;
                    end
                    else
                    begin
                        factor_reg <= rnd[16:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = done_reg;
    assign factor    = factor_reg;

    `DLT_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, state_reg == S_T_DIV, rem_reg < k_reg)
    `DLT_ASSERT_IMPL(a_factor_bounded, clk, rst_n, done_reg, factor_reg <= 17'd65536)
    `DLT_ASSERT_IMPL(a_power_bounded, clk, rst_n, state_reg == S_P_TAKE, i_reg < 4'd12)

endmodule

@@ rtl/decaying_level_table.sv @@
// ----------------------------------------------------------------------------
// Decaying level table
// Levels and decay rates of 256 entries held in two RAMs, with a sequencer.
// ----------------------------------------------------------------------------
// After reset the block clears the level RAM and loads the default rate
// table, one entry a cycle, before it raises in_ready. Set, add, consume,
// set rate and read pass through accept, RAM read, modify and write back,
// and the result register. Decay visits every entry through the RAM port:
// an entry with a zero rate or level is skipped, and an entry that decays
// takes the small-product or the series path of the factor unit, which has
// a shared multiplier and an eight-bit-a-cycle divider. A request is taken
// only when the previous one has finished, so reads never see a stale
// entry. Config writes are taken at any time (cfg_ready is always high).
`include "decaying_level_table_defines.svh"

module decaying_level_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         opcode,
    input  logic [7:0]                         chem_id,
    input  logic signed [dlt_pkg::VAL_W-1:0]   value_in,
    input  logic [dlt_pkg::DT_W-1:0]           time_step,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [dlt_pkg::VAL_W-1:0]   result_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [dlt_pkg::LEVEL_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_D_READ, ST_D_CHECK,
        ST_D_START, ST_D_WAIT, ST_D_WRITE, ST_FINISH
    } state_t;

    localparam int AW = dlt_pkg::ADDR_W;
    localparam int LW = dlt_pkg::LEVEL_W;
    localparam int RW = dlt_pkg::RATE_W;
    localparam int VW = dlt_pkg::VAL_W;

    state_t                           state_reg;
    logic [AW-1:0]                    clr_reg;
    logic [AW-1:0]                    addr_reg;
    logic [2:0]                       op_reg;
    logic                             id_ok_reg;
    logic signed [VW-1:0]             value_reg;
    logic [dlt_pkg::DT_W-1:0]         dt_reg;
    logic signed [VW-1:0]             res_reg;
    logic signed [VW-1:0]             result_reg;
    logic                             out_valid_reg;
    logic [LW-1:0]                    floor_reg;
    logic [LW-1:0]                    ceil_reg;
    logic [dlt_pkg::SNAP_W-1:0]       snap_reg;
    logic [dlt_pkg::X_W-1:0]          x_reg;
    logic [LW-1:0]                    lvl_reg;
    logic [LW+dlt_pkg::FAC_W-1:0]     lmul_reg;

    logic                             lvl_we;
    logic [LW-1:0]                    lvl_wdata;
    logic [LW-1:0]                    lvl_rdata;
    logic                             rate_we;
    logic [RW-1:0]                    rate_wdata;
    logic [RW-1:0]                    rate_rdata;
    logic [AW-1:0]                    waddr;

    logic                             fac_start;
    dlt_pkg::dlt_fac_stat_t           fac_stat;
    logic [dlt_pkg::FAC_W-1:0]        fac_value;

    logic [LW-1:0]                    exec_level;
    logic                             exec_lvl_we;
    logic                             exec_rate_we;
    logic [RW-1:0]                    exec_rate;
    logic signed [VW-1:0]             exec_res;
    logic [25:0]                      decay_level;
    logic                             last_entry;

    dlt_ram #(.WIDTH(LW), .DEPTH(dlt_pkg::ENTRIES)) u_levels (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (waddr),
        .wdata (lvl_wdata),
        .raddr (addr_reg),
        .rdata (lvl_rdata)
    );

    dlt_ram #(.WIDTH(RW), .DEPTH(dlt_pkg::ENTRIES)) u_rates (
        .clk   (clk),
        .we    (rate_we),
        .waddr (waddr),
        .wdata (rate_wdata),
        .raddr (addr_reg),
        .rdata (rate_rdata)
    );

    dlt_factor u_factor (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fac_start),
        .x      (x_reg),
        .stat   (fac_stat),
        .factor (fac_value)
    );

    // Single-entry operations on the level just read, or on the rate for set rate.
    always_comb
    begin
        logic signed [25:0] v_s;
        logic signed [25:0] before_s;
        logic signed [25:0] floor_s;
        logic signed [25:0] ceil_s;
        logic signed [25:0] t_s;
        logic signed [25:0] after_s;
        v_s      = {value_reg[VW-1], value_reg};
        before_s = {2'b00, lvl_rdata};
        floor_s  = {2'b00, floor_reg};
        ceil_s   = {2'b00, ceil_reg};
        t_s      = v_s;
        after_s  = before_s;
        exec_lvl_we  = 1'b0;
        exec_rate_we = 1'b0;
        exec_rate    = '0;
        exec_res     = '0;
        unique case (op_reg)
            dlt_pkg::OP_SET, dlt_pkg::OP_ADD:
            begin
                t_s = (op_reg == dlt_pkg::OP_ADD) ? before_s + v_s : v_s;
                // The floor is applied last, so it wins over the ceiling.
                if (t_s > ceil_s)
                begin
                    t_s = ceil_s;
                end
                if (t_s < floor_s)
                begin
                    t_s = floor_s;
                end
                after_s     = t_s;
                exec_lvl_we = id_ok_reg;
                if (op_reg == dlt_pkg::OP_ADD)
                begin
                    exec_res = VW'(after_s - before_s);
                end
            end
            dlt_pkg::OP_CONSUME:
            begin
                t_s     = (v_s < before_s) ? v_s : before_s;
                after_s = before_s - t_s;
                if (after_s > 26'sd16777215)
                begin
                    after_s = {2'b00, dlt_pkg::LEVEL_MAX};
                end
                exec_lvl_we = id_ok_reg;
                exec_res    = VW'(before_s - after_s);
            end
            dlt_pkg::OP_SET_RATE:
            begin
                if (v_s < 26'sd0)
                begin
                    exec_rate = '0;
                end
                else if (v_s > 26'sd1048575)
                begin
                    exec_rate = dlt_pkg::RATE_MAX;
                end
                else
                begin
                    exec_rate = value_reg[RW-1:0];
                end
                exec_rate_we = id_ok_reg;
            end
            dlt_pkg::OP_READ:
            begin
                exec_res = VW'(before_s);
            end
            default:
            begin
                exec_res = '0;
            end
        endcase
        if (!id_ok_reg)
        begin
            exec_res = '0;
        end
        exec_level = after_s[LW-1:0];
    end

    assign decay_level = 26'((42'(lmul_reg) + 42'd32768) >> 16);
    assign last_entry  = (addr_reg == AW'(dlt_pkg::ENTRIES - 1));

    always_comb
    begin
        lvl_we     = 1'b0;
        lvl_wdata  = '0;
        rate_we    = 1'b0;
        rate_wdata = '0;
        waddr      = addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                waddr      = clr_reg;
                lvl_we     = 1'b1;
                rate_we    = 1'b1;
                rate_wdata = dlt_pkg::default_rate(8'(clr_reg));
            end
            ST_EXEC:
            begin
                lvl_we     = exec_lvl_we;
                lvl_wdata  = exec_level;
                rate_we    = exec_rate_we;
                rate_wdata = exec_rate;
            end
            ST_D_WRITE:
            begin
                lvl_we = 1'b1;
                if (decay_level < 26'(snap_reg))
                begin
                    lvl_wdata = '0;
                end
                else
                begin
                    lvl_wdata = decay_level[LW-1:0];
                end
            end
            default:
            begin
                lvl_we = 1'b0;
            end
        endcase
    end

    assign fac_start = (state_reg == ST_D_START);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_D_CHECK)
        begin
            x_reg   <= rate_rdata * dt_reg;
            lvl_reg <= lvl_rdata;
        end
        if (state_reg == ST_D_WAIT && fac_stat.done)
        begin
            lmul_reg <= lvl_reg * fac_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= dlt_pkg::FLOOR_RST;
            ceil_reg  <= dlt_pkg::CEILING_RST;
            snap_reg  <= dlt_pkg::SNAP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dlt_pkg::REG_FLOOR:   floor_reg <= cfg_data;
                dlt_pkg::REG_CEILING: ceil_reg  <= cfg_data;
                dlt_pkg::REG_SNAP:    snap_reg  <= cfg_data[dlt_pkg::SNAP_W-1:0];
                default:              snap_reg  <= snap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            addr_reg      <= '0;
            op_reg        <= '0;
            id_ok_reg     <= 1'b0;
            value_reg     <= '0;
            dt_reg        <= '0;
            res_reg       <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the finish state the result register is handled below.
            if (out_valid_reg && out_ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(dlt_pkg::ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= opcode;
                        value_reg <= value_in;
                        dt_reg    <= time_step;
                        id_ok_reg <= ({1'b0, chem_id} < 9'(dlt_pkg::ENTRIES));
                        res_reg   <= '0;
                        if (opcode == dlt_pkg::OP_DECAY)
                        begin
                            addr_reg  <= '0;
                            state_reg <= ST_D_READ;
                        end
                        else
                        begin
                            addr_reg  <= chem_id[AW-1:0];
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    res_reg   <= exec_res;
                    state_reg <= ST_FINISH;
                end
                ST_D_READ:
                begin
                    state_reg <= ST_D_CHECK;
                end
                ST_D_CHECK:
                begin
                    if (rate_rdata != '0 && lvl_rdata != '0)
                    begin
                        state_reg <= ST_D_START;
                    end
                    else if (last_entry)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + AW'(1);
                        state_reg <= ST_D_READ;
                    end
                end
                ST_D_START:
                begin
                    state_reg <= ST_D_WAIT;
                end
                ST_D_WAIT:
                begin
                    if (fac_stat.done)
                    begin
                        state_reg <= ST_D_WRITE;
                    end
                end
                ST_D_WRITE:
                begin
                    if (last_entry)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + AW'(1);
                        state_reg <= ST_D_READ;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;

    `DLT_ASSERT_IMPL(a_start_when_free, clk, rst_n, fac_start, !fac_stat.busy)
    `DLT_ASSERT_NEXT(a_finish_presents, clk, rst_n,
        state_reg == ST_FINISH && (!out_valid_reg || out_ready), out_valid_reg)
    `DLT_ASSERT_IMPL(a_done_only_waiting, clk, rst_n, fac_stat.done, state_reg == ST_D_WAIT)
    `DLT_ASSERT_IMPL(a_no_write_idle, clk, rst_n, state_reg == ST_IDLE, !lvl_we && !rate_we)

endmodule
